FILE: rtl/core/pmd_pkg.sv
// ----------------------------------------------------------------------------
// pmd_pkg: shared types and constants of the packet-length Morse decoder
// Holds the command passed from front to back, the register bank layout,
// result kinds, printable characters and the Morse code table.
// ----------------------------------------------------------------------------
package pmd_pkg;

  // Result kinds.
  localparam logic [2:0] KIND_CHAR         = 3'd0;
  localparam logic [2:0] KIND_UNMATCHED    = 3'd1;
  localparam logic [2:0] KIND_OUT_OF_ORDER = 3'd2;
  localparam logic [2:0] KIND_WRONG_SENDER = 3'd3;
  localparam logic [2:0] KIND_BAD_LENGTH   = 3'd4;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_EXPECTED_SENDER = 3'd0;
  localparam logic [2:0] REG_HEADER_BYTES    = 3'd1;
  localparam logic [2:0] REG_DASH_LENGTH     = 3'd2;
  localparam logic [2:0] REG_DOT_LENGTH      = 3'd3;
  localparam logic [2:0] REG_CHAR_GAP_LENGTH = 3'd4;
  localparam logic [2:0] REG_WORD_GAP_LENGTH = 3'd5;
  localparam logic [2:0] REG_END_LENGTH      = 3'd6;

  // Register reset values.
  localparam logic [31:0] DEF_EXPECTED_SENDER = 32'd0;
  localparam logic [5:0]  DEF_HEADER_BYTES    = 6'd20;
  localparam logic [10:0] DEF_DASH_LENGTH     = 11'd300;
  localparam logic [10:0] DEF_DOT_LENGTH      = 11'd100;
  localparam logic [10:0] DEF_CHAR_GAP_LENGTH = 11'd10;
  localparam logic [10:0] DEF_WORD_GAP_LENGTH = 11'd15;
  localparam logic [10:0] DEF_END_LENGTH      = 11'd400;

  // Printable characters produced by the back end.
  localparam logic [7:0] CH_OPEN    = 8'h5B;
  localparam logic [7:0] CH_CLOSE   = 8'h5D;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  typedef struct packed {
    logic [31:0] expected_sender;
    logic [5:0]  header_bytes;
    logic [10:0] dash_length;
    logic [10:0] dot_length;
    logic [10:0] char_gap_length;
    logic [10:0] word_gap_length;
    logic [10:0] end_length;
  } pmd_cfg_t;

  typedef enum logic [1:0] {
    CMD_WRONG_SENDER,
    CMD_OUT_OF_ORDER,
    CMD_BAD_LENGTH,
    CMD_FLUSH
  } pmd_op_t;

  typedef enum logic [1:0] {
    TRAIL_NONE,
    TRAIL_SPACE,
    TRAIL_NEWLINE
  } pmd_trail_t;

  // One queued command. The pattern snapshot travels beside it.
  typedef struct packed {
    pmd_op_t    op;
    pmd_trail_t trail;
    logic [31:0] value;
  } pmd_cmd_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_LOOKUP,
    BS_SYMBOLS,
    BS_CLOSE,
    BS_TRAILER
  } pmd_bstate_t;

  // Morse table entry. The code is read first symbol at the MSB of a
  // len-bit value, a dash being 1 and a dot 0.
  typedef struct packed {
    logic [7:0] ch;
    logic [2:0] len;
    logic [6:0] code;
  } pmd_morse_t;

  localparam int TABLE_SIZE = 61;

  localparam pmd_morse_t MORSE_TABLE [TABLE_SIZE] = '{
    '{8'h22, 3'd6, 7'b0010010}, '{8'h27, 3'd6, 7'b0011110},
    '{8'h28, 3'd5, 7'b0010110}, '{8'h29, 3'd6, 7'b0101101},
    '{8'h2C, 3'd6, 7'b0110011}, '{8'h2D, 3'd6, 7'b0100001},
    '{8'h2E, 3'd6, 7'b0010101}, '{8'h2F, 3'd5, 7'b0010010},
    '{8'h26, 3'd5, 7'b0001000}, '{8'h3D, 3'd5, 7'b0010001},
    '{8'h3A, 3'd6, 7'b0111000}, '{8'h3B, 3'd5, 7'b0010101},
    '{8'h2B, 3'd5, 7'b0001010}, '{8'h5F, 3'd6, 7'b0001101},
    '{8'h24, 3'd7, 7'b0001001}, '{8'h40, 3'd6, 7'b0011010},
    '{8'h30, 3'd5, 7'b0011111}, '{8'h31, 3'd5, 7'b0001111},
    '{8'h32, 3'd5, 7'b0000111}, '{8'h33, 3'd5, 7'b0000011},
    '{8'h34, 3'd5, 7'b0000001}, '{8'h35, 3'd5, 7'b0000000},
    '{8'h36, 3'd5, 7'b0010000}, '{8'h37, 3'd5, 7'b0011000},
    '{8'h38, 3'd5, 7'b0011100}, '{8'h39, 3'd5, 7'b0011110},
    '{8'h3A, 3'd6, 7'b0111000}, '{8'h3F, 3'd6, 7'b0001100},
    '{8'h41, 3'd2, 7'b0000001}, '{8'h42, 3'd4, 7'b0001000},
    '{8'h43, 3'd4, 7'b0001010}, '{8'h44, 3'd3, 7'b0000100},
    '{8'h45, 3'd1, 7'b0000000}, '{8'h46, 3'd4, 7'b0000010},
    '{8'h47, 3'd3, 7'b0000110}, '{8'h48, 3'd4, 7'b0000000},
    '{8'h49, 3'd2, 7'b0000000}, '{8'h4A, 3'd4, 7'b0000111},
    '{8'h4B, 3'd3, 7'b0000101}, '{8'h4C, 3'd4, 7'b0000100},
    '{8'h4D, 3'd2, 7'b0000011}, '{8'h4E, 3'd2, 7'b0000010},
    '{8'h4F, 3'd3, 7'b0000111}, '{8'h50, 3'd4, 7'b0000110},
    '{8'h51, 3'd4, 7'b0001101}, '{8'h52, 3'd3, 7'b0000010},
    '{8'h53, 3'd3, 7'b0000000}, '{8'h54, 3'd1, 7'b0000001},
    '{8'h55, 3'd3, 7'b0000001}, '{8'h56, 3'd4, 7'b0000001},
    '{8'h57, 3'd3, 7'b0000011}, '{8'h58, 3'd4, 7'b0001001},
    '{8'h59, 3'd4, 7'b0001011}, '{8'h5A, 3'd4, 7'b0001100},
    '{8'hC5, 3'd5, 7'b0001101}, '{8'hC4, 3'd4, 7'b0000101},
    '{8'hC0, 3'd5, 7'b0001101}, '{8'hC9, 3'd5, 7'b0000100},
    '{8'hD1, 3'd5, 7'b0011011}, '{8'hD6, 3'd4, 7'b0001110},
    '{8'hDC, 3'd4, 7'b0000011}
  };

  // Returns {hit, character}. The first matching entry wins, so the scan
  // runs from the end and lets earlier entries overwrite later ones.
  function automatic logic [8:0] morse_lookup(input logic [2:0] len,
                                              input logic [6:0] code);
    logic [8:0] res;
    logic [6:0] mask;
    res = 9'd0;
    for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
      mask = ~(7'h7F << MORSE_TABLE[i].len);
      if (MORSE_TABLE[i].len == len && (code & mask) == MORSE_TABLE[i].code) begin
        res = {1'b1, MORSE_TABLE[i].ch};
      end
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/packet_length_morse_decoder.sv
// ----------------------------------------------------------------------------
// packet_length_morse_decoder: Morse decoder driven by packet lengths
// Timing: a packet is checked and classified in its accept cycle; its first
//   result beat passes the command queue, then for a flush the lookup state,
//   then the output register. One result beat per cycle leaves the sequencer
//   unless the output stalls; a packet costs 0 to MAX_SYMBOLS+3 beats.
// Reset: synchronous, active low; registers return to their defaults, the
//   expected sequence and the pattern count clear. No clearing pass.
// ----------------------------------------------------------------------------
module packet_length_morse_decoder
  import pmd_pkg::*;
#(
  parameter int MAX_SYMBOLS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Packet input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_source_address,
  input  logic [31:0] in_sequence_number,
  input  logic [10:0] in_packet_length,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_character,
  output logic [31:0] out_reported_value,
  output logic        out_last,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // The pattern count has to hold MAX_SYMBOLS itself, since a full pattern
  // stays full and ignores further symbols.
  localparam int CW = $clog2(MAX_SYMBOLS + 1);
  localparam int QW = $bits(pmd_cmd_t) + MAX_SYMBOLS + CW;

  // Register bank. Writes are taken in any cycle; the user only writes while
  // the block is quiet, so no hold-off against in-flight packets is needed.
  pmd_cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_EXPECTED_SENDER: cfg_nxt.expected_sender = cfg_data;
        REG_HEADER_BYTES:    cfg_nxt.header_bytes    = cfg_data[5:0];
        REG_DASH_LENGTH:     cfg_nxt.dash_length     = cfg_data[10:0];
        REG_DOT_LENGTH:      cfg_nxt.dot_length      = cfg_data[10:0];
        REG_CHAR_GAP_LENGTH: cfg_nxt.char_gap_length = cfg_data[10:0];
        REG_WORD_GAP_LENGTH: cfg_nxt.word_gap_length = cfg_data[10:0];
        REG_END_LENGTH:      cfg_nxt.end_length      = cfg_data[10:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_sender <= DEF_EXPECTED_SENDER;
      cfg_r.header_bytes    <= DEF_HEADER_BYTES;
      cfg_r.dash_length     <= DEF_DASH_LENGTH;
      cfg_r.dot_length      <= DEF_DOT_LENGTH;
      cfg_r.char_gap_length <= DEF_CHAR_GAP_LENGTH;
      cfg_r.word_gap_length <= DEF_WORD_GAP_LENGTH;
      cfg_r.end_length      <= DEF_END_LENGTH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The front end owns the sequence counter and the symbol pattern. Dots and
  // dashes only grow the pattern; every other packet becomes one command,
  // and a flush carries a snapshot of the pattern so the front end can start
  // the next character at once.
  logic                   f_push;
  pmd_cmd_t               f_cmd;
  logic [MAX_SYMBOLS-1:0] f_pat;
  logic [CW-1:0]          f_cnt;
  logic                   q_full, q_empty, q_pop;
  logic [QW-1:0]          q_rdata;
  pmd_cmd_t               b_cmd;
  logic [MAX_SYMBOLS-1:0] b_pat;
  logic [CW-1:0]          b_cnt;

  pmd_front #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_source_address (in_source_address),
    .in_sequence_number(in_sequence_number),
    .in_packet_length  (in_packet_length),
    .q_full            (q_full),
    .q_push            (f_push),
    .q_cmd             (f_cmd),
    .q_pat             (f_pat),
    .q_cnt             (f_cnt)
  );

  // A short queue lets the front end keep taking packets while the back end
  // spells out a long unmatched pattern.
  pmd_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_push),
    .push_data({f_cmd, f_pat, f_cnt}),
    .pop      (q_pop),
    .pop_data (q_rdata),
    .full     (q_full),
    .empty    (q_empty)
  );

  assign {b_cmd, b_pat, b_cnt} = q_rdata;

  // The back end looks the pattern up in the Morse table and emits the
  // result beats through its output register.
  pmd_back #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_cmd             (b_cmd),
    .q_pat             (b_pat),
    .q_cnt             (b_cnt),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_character     (out_character),
    .out_reported_value(out_reported_value),
    .out_last          (out_last)
  );

  // The front end must never push into a full queue.
  assert property (@(posedge clk) disable iff (!rst_n) q_full |-> !f_push)
    else $error("command pushed into a full queue");

  // The back end only pops a command that is there.
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
    else $error("command popped from an empty queue");

  // Event beats carry no character and are always the last beat of a packet.
  assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && (out_kind == KIND_OUT_OF_ORDER || out_kind == KIND_WRONG_SENDER ||
                    out_kind == KIND_BAD_LENGTH)
      |-> out_character == 8'd0 && out_last)
    else $error("event beat with a character or without last");

  // Unmatched-pattern beats never carry a reported value.
  assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_kind == KIND_UNMATCHED |-> out_reported_value == 32'd0)
    else $error("unmatched-pattern beat with a reported value");

endmodule

FILE: rtl/core/pmd_front.sv
// ----------------------------------------------------------------------------
// pmd_front: packet checker and classifier
// Checks sender and sequence, classifies the payload length, builds the
// symbol pattern and queues a command for every packet that gives results.
// ----------------------------------------------------------------------------
module pmd_front
  import pmd_pkg::*;
#(
  parameter int MAX_SYMBOLS = 16,
  localparam int CW = $clog2(MAX_SYMBOLS + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pmd_cfg_t               cfg,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [31:0]            in_source_address,
  input  logic [31:0]            in_sequence_number,
  input  logic [10:0]            in_packet_length,
  input  logic                   q_full,
  output logic                   q_push,
  output pmd_cmd_t               q_cmd,
  output logic [MAX_SYMBOLS-1:0] q_pat,
  output logic [CW-1:0]          q_cnt
);

  logic [31:0]            exp_seq_r, exp_seq_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [MAX_SYMBOLS-1:0] pat_r, pat_nxt;
  logic                   accept;
  logic                   hdr_ok;
  logic [10:0]            payload;
  logic                   room;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign hdr_ok   = in_packet_length >= {5'd0, cfg.header_bytes};
  assign payload  = in_packet_length - {5'd0, cfg.header_bytes};
  assign room     = cnt_r < CW'(MAX_SYMBOLS);
  assign q_pat    = pat_r;
  assign q_cnt    = cnt_r;

  always_comb begin
    exp_seq_nxt = exp_seq_r;
    cnt_nxt     = cnt_r;
    pat_nxt     = pat_r;
    q_push      = 1'b0;
    q_cmd.op    = CMD_FLUSH;
    q_cmd.trail = TRAIL_NONE;
    q_cmd.value = 32'd0;
    if (accept) begin
      priority if (in_source_address != cfg.expected_sender) begin
        q_push   = 1'b1;
        q_cmd.op = CMD_WRONG_SENDER;
      end else if (in_sequence_number != exp_seq_r) begin
        q_push      = 1'b1;
        q_cmd.op    = CMD_OUT_OF_ORDER;
        q_cmd.value = in_sequence_number;
        exp_seq_nxt = 32'd0;
      end else begin
        exp_seq_nxt = exp_seq_r + 32'd1;
        priority if (hdr_ok && payload == cfg.dash_length) begin
          if (room) begin
            pat_nxt = {pat_r[MAX_SYMBOLS-2:0], 1'b1};
            cnt_nxt = cnt_r + CW'(1);
          end
        end else if (hdr_ok && payload == cfg.dot_length) begin
          if (room) begin
            pat_nxt = {pat_r[MAX_SYMBOLS-2:0], 1'b0};
            cnt_nxt = cnt_r + CW'(1);
          end
        end else if (hdr_ok && payload == cfg.word_gap_length) begin
          q_push      = 1'b1;
          q_cmd.trail = TRAIL_SPACE;
          cnt_nxt     = '0;
        end else if (hdr_ok && payload == cfg.char_gap_length) begin
          q_push  = 1'b1;
          cnt_nxt = '0;
        end else if (hdr_ok && payload == cfg.end_length) begin
          q_push      = 1'b1;
          q_cmd.trail = TRAIL_NEWLINE;
          cnt_nxt     = '0;
          exp_seq_nxt = 32'd0;
        end else begin
          q_push      = 1'b1;
          q_cmd.op    = CMD_BAD_LENGTH;
          q_cmd.value = {21'd0, in_packet_length};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_seq_r <= 32'd0;
      cnt_r     <= '0;
    end else begin
      exp_seq_r <= exp_seq_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pat_r <= pat_nxt;
  end

endmodule

FILE: rtl/core/pmd_queue.sv
// ----------------------------------------------------------------------------
// pmd_queue: two-entry command queue
// Decouples the classifier from the result sequencer.
// ----------------------------------------------------------------------------
module pmd_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int DEPTH = 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [LW-1:0]    level_r;

  assign full     = level_r == LW'(DEPTH);
  assign empty    = level_r == '0;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        level_r <= level_r + LW'(1);
      end else if (pop && !push) begin
        level_r <= level_r - LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/core/pmd_back.sv
// ----------------------------------------------------------------------------
// pmd_back: result sequencer
// Turns each queued command into its result beats, one beat per cycle while
// the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module pmd_back
  import pmd_pkg::*;
#(
  parameter int MAX_SYMBOLS = 16,
  localparam int CW = $clog2(MAX_SYMBOLS + 1),
  localparam int IW = $clog2(MAX_SYMBOLS)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  pmd_cmd_t               q_cmd,
  input  logic [MAX_SYMBOLS-1:0] q_pat,
  input  logic [CW-1:0]          q_cnt,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             out_kind,
  output logic [7:0]             out_character,
  output logic [31:0]            out_reported_value,
  output logic                   out_last
);

  pmd_bstate_t            state_r, state_nxt;
  logic [MAX_SYMBOLS-1:0] pat_r, pat_nxt;
  logic [CW-1:0]          rem_r, rem_nxt;
  pmd_trail_t             trail_r, trail_nxt;
  logic                   valid_r, valid_nxt;
  logic [2:0]             kind_r, kind_nxt;
  logic [7:0]             char_r, char_nxt;
  logic [31:0]            value_r, value_nxt;
  logic                   last_r, last_nxt;
  logic                   out_free;
  logic [8:0]             lk;
  logic                   hit;
  logic [CW-1:0]          rem_m1;
  logic                   sym;

  assign out_free = !valid_r || !out_stall;
  assign lk       = morse_lookup(rem_r[2:0], pat_r[6:0]);
  assign hit      = (32'(rem_r) <= 32'd7) && lk[8];
  assign rem_m1   = rem_r - CW'(1);
  assign sym      = pat_r[rem_m1[IW-1:0]];

  assign out_valid          = valid_r;
  assign out_kind           = kind_r;
  assign out_character      = char_r;
  assign out_reported_value = value_r;
  assign out_last           = last_r;

  always_comb begin
    state_nxt = state_r;
    pat_nxt   = pat_r;
    rem_nxt   = rem_r;
    trail_nxt = trail_r;
    valid_nxt = valid_r;
    kind_nxt  = kind_r;
    char_nxt  = char_r;
    value_nxt = value_r;
    last_nxt  = last_r;
    q_pop     = 1'b0;
    if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
    unique case (state_r)
      BS_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop = 1'b1;
          if (q_cmd.op == CMD_FLUSH) begin
            pat_nxt   = q_pat;
            rem_nxt   = q_cnt;
            trail_nxt = q_cmd.trail;
            state_nxt = BS_LOOKUP;
          end else begin
            valid_nxt = 1'b1;
            char_nxt  = 8'd0;
            value_nxt = q_cmd.value;
            last_nxt  = 1'b1;
            unique case (q_cmd.op)
              CMD_WRONG_SENDER: kind_nxt = KIND_WRONG_SENDER;
              CMD_OUT_OF_ORDER: kind_nxt = KIND_OUT_OF_ORDER;
              default:          kind_nxt = KIND_BAD_LENGTH;
            endcase
          end
        end
      end
      BS_LOOKUP: begin
        if (out_free) begin
          valid_nxt = 1'b1;
          value_nxt = 32'd0;
          if (hit) begin
            kind_nxt  = KIND_CHAR;
            char_nxt  = lk[7:0];
            last_nxt  = trail_r == TRAIL_NONE;
            state_nxt = (trail_r == TRAIL_NONE) ? BS_IDLE : BS_TRAILER;
          end else begin
            kind_nxt  = KIND_UNMATCHED;
            char_nxt  = CH_OPEN;
            last_nxt  = 1'b0;
            state_nxt = (rem_r == '0) ? BS_CLOSE : BS_SYMBOLS;
          end
        end
      end
      BS_SYMBOLS: begin
        if (out_free) begin
          valid_nxt = 1'b1;
          kind_nxt  = KIND_UNMATCHED;
          char_nxt  = sym ? CH_DASH : CH_DOT;
          value_nxt = 32'd0;
          last_nxt  = 1'b0;
          rem_nxt   = rem_m1;
          if (rem_r == CW'(1)) begin
            state_nxt = BS_CLOSE;
          end
        end
      end
      BS_CLOSE: begin
        if (out_free) begin
          valid_nxt = 1'b1;
          kind_nxt  = KIND_UNMATCHED;
          char_nxt  = CH_CLOSE;
          value_nxt = 32'd0;
          last_nxt  = trail_r == TRAIL_NONE;
          state_nxt = (trail_r == TRAIL_NONE) ? BS_IDLE : BS_TRAILER;
        end
      end
      BS_TRAILER: begin
        if (out_free) begin
          valid_nxt = 1'b1;
          kind_nxt  = KIND_CHAR;
          char_nxt  = (trail_r == TRAIL_SPACE) ? CH_SPACE : CH_NEWLINE;
          value_nxt = 32'd0;
          last_nxt  = 1'b1;
          state_nxt = BS_IDLE;
        end
      end
      default: begin
        state_nxt = BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BS_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pat_r   <= pat_nxt;
    rem_r   <= rem_nxt;
    trail_r <= trail_nxt;
    kind_r  <= kind_nxt;
    char_r  <= char_nxt;
    value_r <= value_nxt;
    last_r  <= last_nxt;
  end

endmodule

FILE: dv/packet_length_morse_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_length_morse_decoder_tb: self-checking bench for the Morse decoder
// Sends packets through the input channel and predicts each result beat from
// a model of the decoder kept in a small scoreboard. Every beat taken from the
// result channel is compared, field by field, with the oldest prediction. The
// run covers the reset defaults and several programmed register sets, random
// idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module packet_length_morse_decoder_tb;
  import pmd_pkg::*;

  localparam int MAX_SYMBOLS   = 16;
  // A dash or dot makes no beat, so the bench leaves some slack after the last
  // beat before touching registers.
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 135;

  // One result beat as seen on the result channel.
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  character;
    logic [31:0] value;
    logic        last;
  } morse_beat_t;

  // --------------------------------------------------------------------------
  // Scoreboard. It keeps its own copy of the registers, the expected sequence
  // number and the pattern collected so far, and turns each accepted packet
  // into the list of beats the decoder must produce for it.
  // --------------------------------------------------------------------------
  class morse_scoreboard;
    logic [31:0] sender;
    logic [5:0]  header;
    logic [10:0] dash_len;
    logic [10:0] dot_len;
    logic [10:0] char_gap_len;
    logic [10:0] word_gap_len;
    logic [10:0] end_len;
    logic [31:0] next_seq;
    // Pattern held as text, one '-' or '.' per symbol.
    string       symbols;
    morse_beat_t beats_due[$];
    int          errors;
    int          beats_seen;
    int          chars_seen;
    int          unmatched_seen;
    int          events_seen;

    function new();
      sender       = DEF_EXPECTED_SENDER;
      header       = DEF_HEADER_BYTES;
      dash_len     = DEF_DASH_LENGTH;
      dot_len      = DEF_DOT_LENGTH;
      char_gap_len = DEF_CHAR_GAP_LENGTH;
      word_gap_len = DEF_WORD_GAP_LENGTH;
      end_len      = DEF_END_LENGTH;
      next_seq     = '0;
      symbols      = "";
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_EXPECTED_SENDER: sender       = data;
        REG_HEADER_BYTES:    header       = data[5:0];
        REG_DASH_LENGTH:     dash_len     = data[10:0];
        REG_DOT_LENGTH:      dot_len      = data[10:0];
        REG_CHAR_GAP_LENGTH: char_gap_len = data[10:0];
        REG_WORD_GAP_LENGTH: word_gap_len = data[10:0];
        REG_END_LENGTH:      end_len      = data[10:0];
        default: ;
      endcase
    endfunction

    function void push(logic [2:0] kind, logic [7:0] ch, logic [31:0] value);
      morse_beat_t b;
      b = '{kind, ch, value, 1'b0};
      beats_due.push_back(b);
    endfunction

    // Morse table lookup. Returns {hit, character}. Codes listed twice in the
    // table (the colon and the A-ring / A-grave code) resolve to the first one.
    function logic [8:0] lookup(string p);
      logic [7:0] ch;
      logic       hit;
      hit = 1'b1;
      ch  = 8'h00;
      case (p)
        ".-..-.": ch = 8'h22;  ".----.": ch = "'";  "-.--.":  ch = "(";
        "-.--.-": ch = ")";    "--..--": ch = ",";  "-....-": ch = "-";
        ".-.-.-": ch = ".";    "-..-.":  ch = "/";  ".-...":  ch = "&";
        "-...-":  ch = "=";    "---...": ch = ":";  "-.-.-":  ch = ";";
        ".-.-.":  ch = "+";    "..--.-": ch = "_";  "...-..-": ch = "$";
        ".--.-.": ch = "@";
        "-----":  ch = "0";    ".----":  ch = "1";  "..---":  ch = "2";
        "...--":  ch = "3";    "....-":  ch = "4";  ".....":  ch = "5";
        "-....":  ch = "6";    "--...":  ch = "7";  "---..":  ch = "8";
        "----.":  ch = "9";    "..--..": ch = "?";
        ".-":   ch = "A";  "-...": ch = "B";  "-.-.": ch = "C";  "-..":  ch = "D";
        ".":    ch = "E";  "..-.": ch = "F";  "--.":  ch = "G";  "....": ch = "H";
        "..":   ch = "I";  ".---": ch = "J";  "-.-":  ch = "K";  ".-..": ch = "L";
        "--":   ch = "M";  "-.":   ch = "N";  "---":  ch = "O";  ".--.": ch = "P";
        "--.-": ch = "Q";  ".-.":  ch = "R";  "...":  ch = "S";  "-":    ch = "T";
        "..-":  ch = "U";  "...-": ch = "V";  ".--":  ch = "W";  "-..-": ch = "X";
        "-.--": ch = "Y";  "--..": ch = "Z";
        // Latin-1 letters.
        ".--.-": ch = 8'hC5;  ".-.-":  ch = 8'hC4;  "..-..": ch = 8'hC9;
        "--.--": ch = 8'hD1;  "---.":  ch = 8'hD6;  "..--":  ch = 8'hDC;
        default: hit = 1'b0;
      endcase
      return {hit, ch};
    endfunction

    // Looks the pattern up and clears it. A miss, the empty pattern too, is
    // spelled out between brackets.
    function void close_pattern();
      logic [8:0] hit_ch;
      hit_ch = lookup(symbols);
      if (hit_ch[8]) begin
        push(KIND_CHAR, hit_ch[7:0], '0);
      end else begin
        push(KIND_UNMATCHED, CH_OPEN, '0);
        for (int i = 0; i < symbols.len(); i++) begin
          push(KIND_UNMATCHED, (symbols[i] == "-") ? CH_DASH : CH_DOT, '0);
        end
        push(KIND_UNMATCHED, CH_CLOSE, '0);
      end
      symbols = "";
    endfunction

    // A full pattern ignores further symbols.
    function void add_symbol(bit is_dash);
      if (symbols.len() < MAX_SYMBOLS) begin
        if (is_dash) symbols = {symbols, "-"};
        else symbols = {symbols, "."};
      end
    endfunction

    // Called for every accepted input beat.
    function void note_packet(logic [31:0] src, logic [31:0] seq, logic [10:0] len);
      int          first;
      logic        len_ok;
      logic [10:0] payload;
      morse_beat_t tail;
      first = beats_due.size();
      if (src != sender) begin
        push(KIND_WRONG_SENDER, '0, '0);
      end else if (seq != next_seq) begin
        next_seq = '0;
        push(KIND_OUT_OF_ORDER, '0, seq);
      end else begin
        len_ok   = (len >= {5'd0, header});
        payload  = len - {5'd0, header};
        next_seq = next_seq + 32'd1;
        // The class checks run in priority order, which matters when two
        // registers hold the same length.
        if (len_ok && payload == dash_len) begin
          add_symbol(1'b1);
        end else if (len_ok && payload == dot_len) begin
          add_symbol(1'b0);
        end else if (len_ok && payload == word_gap_len) begin
          close_pattern();
          push(KIND_CHAR, CH_SPACE, '0);
        end else if (len_ok && payload == char_gap_len) begin
          close_pattern();
        end else if (len_ok && payload == end_len) begin
          close_pattern();
          push(KIND_CHAR, CH_NEWLINE, '0);
          next_seq = '0;
        end else begin
          push(KIND_BAD_LENGTH, '0, {21'd0, len});
        end
      end
      // Mark the final beat that this packet caused.
      if (beats_due.size() > first) begin
        tail      = beats_due.pop_back();
        tail.last = 1'b1;
        beats_due.push_back(tail);
      end
    endfunction

    // Called for every accepted result beat.
    function void check_beat(morse_beat_t got);
      morse_beat_t want;
      if (beats_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat: expected none, %s", $time,
                 $sformatf("got kind %0d char %02h value %08h last %b",
                           got.kind, got.character, got.value, got.last));
        return;
      end
      want = beats_due.pop_front();
      beats_seen++;
      if (got !== want) begin
        errors++;
        $display("%0t: beat mismatch: expected kind %0d char %02h value %08h last %b, %s",
                 $time, want.kind, want.character, want.value, want.last,
                 $sformatf("got kind %0d char %02h value %08h last %b",
                           got.kind, got.character, got.value, got.last));
      end
      case (want.kind)
        KIND_CHAR:      chars_seen++;
        KIND_UNMATCHED: unmatched_seen++;
        default:        events_seen++;
      endcase
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals. Every input of the decoder starts at a known value.
  // --------------------------------------------------------------------------
  logic        clk                = 1'b0;
  logic        rst_n              = 1'b0;
  logic        in_valid           = 1'b0;
  logic        in_stall;
  logic [31:0] in_source_address  = '0;
  logic [31:0] in_sequence_number = '0;
  logic [10:0] in_packet_length   = '0;
  logic        out_valid;
  logic        out_stall          = 1'b0;
  logic [2:0]  out_kind;
  logic [7:0]  out_character;
  logic [31:0] out_reported_value;
  logic        out_last;
  logic        cfg_valid          = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index          = '0;
  logic [31:0] cfg_data           = '0;

  // Idle rates in percent for the sender and the receiver, and the flag that
  // holds the receiver off for a long stretch.
  int              in_idle_pct  = 0;
  int              out_idle_pct = 0;
  bit              hold_off     = 1'b0;
  int              packets_sent = 0;
  morse_scoreboard sb           = new();

  packet_length_morse_decoder #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_source_address (in_source_address),
    .in_sequence_number(in_sequence_number),
    .in_packet_length  (in_packet_length),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_character     (out_character),
    .out_reported_value(out_reported_value),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver side. The stall changes at the falling edge only, either at
  // random or for the whole of a hold-off.
  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < out_idle_pct);
  end

  // Result monitor. Sampling at the rising edge sees the values from before
  // the edge, so a beat counts exactly when the decoder hands it over.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_beat('{out_kind, out_character, out_reported_value, out_last});
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks. Inputs change at the falling edge; handshakes are sampled
  // at the rising edge.
  // --------------------------------------------------------------------------

  // One register write. Valid stays up between back-to-back writes.
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // Writes the whole register bank. Only called while the decoder is idle.
  task automatic program_regs(input logic [31:0] sender, input logic [5:0] hdr,
                              input logic [10:0] dash, input logic [10:0] dot,
                              input logic [10:0] cgap, input logic [10:0] wgap,
                              input logic [10:0] eom);
    cfg_write(REG_EXPECTED_SENDER, sender);
    cfg_write(REG_HEADER_BYTES, {26'd0, hdr});
    cfg_write(REG_DASH_LENGTH, {21'd0, dash});
    cfg_write(REG_DOT_LENGTH, {21'd0, dot});
    cfg_write(REG_CHAR_GAP_LENGTH, {21'd0, cgap});
    cfg_write(REG_WORD_GAP_LENGTH, {21'd0, wgap});
    cfg_write(REG_END_LENGTH, {21'd0, eom});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Offers one packet, after a random number of idle cycles, and holds it
  // steady until the decoder takes it.
  task automatic send_packet(input logic [31:0] src, input logic [31:0] seq,
                             input logic [10:0] len);
    while ($urandom_range(99) < in_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid           <= 1'b1;
    in_source_address  <= src;
    in_sequence_number <= seq;
    in_packet_length   <= len;
    do @(posedge clk); while (in_stall);
    sb.note_packet(src, seq, len);
    packets_sent++;
  endtask

  // A well-formed packet whose payload has the given length. Lengths that do
  // not fit behind the header become a random length instead.
  task automatic send_payload(input logic [10:0] payload);
    int total;
    total = int'(sb.header) + int'(payload);
    if (total > 1500) total = $urandom_range(1500);
    send_packet(sb.sender, sb.next_seq, total[10:0]);
  endtask

  // A packet that breaks the stream: foreign sender, wrong sequence number,
  // arbitrary length or a packet shorter than the header.
  task automatic send_noise();
    logic [31:0] src;
    logic [31:0] seq;
    case ($urandom_range(3))
      0: begin
        src = $urandom;
        if (src == sb.sender) src = ~src;
        send_packet(src, sb.next_seq, 11'($urandom_range(1500)));
      end
      1: begin
        seq = $urandom_range(1) ? 32'($urandom) : sb.next_seq + 32'd1;
        send_packet(sb.sender, seq, 11'($urandom_range(1500)));
      end
      2: send_packet(sb.sender, sb.next_seq, 11'($urandom_range(1500)));
      default: begin
        if (sb.header == 0) send_packet(sb.sender, sb.next_seq, 11'd0);
        else send_packet(sb.sender, sb.next_seq, 11'($urandom_range(sb.header - 1)));
      end
    endcase
  endtask

  // One Morse character: a run of dashes and dots closed by a gap or an end.
  // Most runs are short enough to hit the table; a few overfill the pattern.
  // Noise packets are sprinkled in between.
  task automatic send_character();
    int n;
    int pick;
    pick = $urandom_range(99);
    if (pick < 6) n = 0;
    else if (pick < 88) n = $urandom_range(1, 6);
    else n = $urandom_range(7, MAX_SYMBOLS + 4);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 8) send_noise();
      send_payload($urandom_range(1) ? sb.dash_len : sb.dot_len);
    end
    if ($urandom_range(99) < 8) send_noise();
    pick = $urandom_range(99);
    if (pick < 60) send_payload(sb.char_gap_len);
    else if (pick < 85) send_payload(sb.word_gap_len);
    else send_payload(sb.end_len);
  endtask

  task automatic send_random(input int count);
    int start;
    start = packets_sent;
    while (packets_sent - start < count) send_character();
  endtask

  // Lowers valid, waits for every predicted beat, then lets the decoder
  // settle so that registers can be written safely.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin : main_seq
    // Reset is held low from the start and released at a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part on the reset defaults, so the default register values
    // are checked as well. The empty pattern is spelled as an empty bracket.
    send_payload(sb.char_gap_len);
    // Dot, dash: the letter A.
    send_payload(sb.dot_len);
    send_payload(sb.dash_len);
    send_payload(sb.char_gap_len);
    // Three dashes and a word gap: O, then a space.
    repeat (3) send_payload(sb.dash_len);
    send_payload(sb.word_gap_len);
    // Foreign sender with all address bits set.
    send_packet(32'hFFFF_FFFF, sb.next_seq, 11'd320);
    // Largest sequence number out of order; the sequence restarts at zero.
    send_packet(sb.sender, 32'hFFFF_FFFF, 11'd120);
    // Zero-length packet, shorter than the header.
    send_packet(sb.sender, sb.next_seq, 11'd0);
    // Largest packet, matching no class.
    send_packet(sb.sender, sb.next_seq, 11'd1500);
    // Dot and end of message: E, then a newline.
    send_payload(sb.dot_len);
    send_payload(sb.end_len);
    wait_drained();

    // Equal class lengths: dash wins over dot, and word gap wins over both
    // char gap and end. No header, so the length is the payload.
    program_regs(32'hFFFF_FFFF, 6'd0, 11'd40, 11'd40, 11'd60, 11'd60, 11'd60);
    send_payload(11'd40);
    send_payload(11'd60);
    send_payload(11'd60);
    wait_drained();

    // Random part, first mix: the sender idles rarely, the receiver often.
    // The register set is random with every class reachable.
    in_idle_pct  = 18;
    out_idle_pct = 72;
    program_regs($urandom, 6'($urandom_range(60)), 11'($urandom_range(1440)),
                 11'($urandom_range(1440)), 11'($urandom_range(1440)),
                 11'($urandom_range(1440)), 11'($urandom_range(1440)));
    send_random(RANDOM_ITEMS);
    wait_drained();

    // Second mix, the other way round, on one extreme of the registers:
    // no header, zero and full-scale lengths, all-ones sender.
    in_idle_pct  = 72;
    out_idle_pct = 18;
    program_regs(32'hFFFF_FFFF, 6'd0, 11'd0, 11'd1480, 11'd1479, 11'd1, 11'd740);
    send_random(RANDOM_ITEMS);
    wait_drained();

    // Third mix: no idling, largest header, and a long hold-off on the
    // receiver at the start so the decoder backs up and stalls its input.
    in_idle_pct  = 0;
    out_idle_pct = 0;
    program_regs($urandom, 6'd60, 11'd1440, 11'd0, 11'd700, 11'd701, 11'd1);
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    send_random(RANDOM_ITEMS);
    wait_drained();

    $display("Run summary: %0d packets in, %0d beats checked", packets_sent,
             sb.beats_seen);
    $display("(%0d chars, %0d bracket beats, %0d events); register sets: %s",
             sb.chars_seen, sb.unmatched_seen, sb.events_seen,
             "defaults, equal lengths, random and two extremes; three idle mixes.");
    if (sb.errors == 0) begin
      $display("packet_length_morse_decoder verification clean");
    end else begin
      $display("packet_length_morse_decoder verification failed");
    end
    $finish;
  end

  // Watchdog. The slowest correct run is far below this; anything longer
  // means a beat or a handshake is stuck.
  initial begin : watchdog
    #5_000_000;
    $display("%0t: run did not complete, %0d beats still expected", $time,
             sb.beats_due.size());
    $display("packet_length_morse_decoder verification failed");
    $finish;
  end

endmodule
